### src/clnf_pkg.sv
package clnf_pkg;

    // Default number of decimal digit stages.
    localparam int MAX_DIGITS_DEF = 5;

    // DDRAM base address of each display row, set-address command bit included.
    localparam logic [3:0][7:0] ROW_BASE = {8'hD4, 8'h94, 8'hC0, 8'h80};

    localparam logic [7:0] CHR_ZERO      = 8'h30;
    localparam logic [7:0] CHR_HEX_ALPHA = 8'h37;
    localparam logic [7:0] CHR_SPACE     = 8'h20;

    // floor(v / 10) == (v * DIV10_MULT) >> DIV10_SHIFT for every 16-bit v.
    localparam logic [16:0] DIV10_MULT  = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] base;
        base = (nib > 4'd9) ? CHR_HEX_ALPHA : CHR_ZERO;
        return base + {4'd0, nib};
    endfunction

endpackage

### src/char_lcd_number_formatter_unit.sv
// Character LCD number formatter.
// Input channel (i_valid / o_ready): one transaction asks for one number to be
// written at a row and column of a 4-row character LCD.
// Output channel (o_valid / i_ready): one transaction is one LCD bus write. Each
// request first yields a set-address command (o_is_data low), then its
// characters as data writes; o_last marks the final write of a request.
// Decimal mode writes 2 to MAX_DIGITS digits, with optional leading-zero
// blanking; hex mode writes the low byte as two uppercase characters.
// A request passes an input stage and MAX_DIGITS digit stages, each of which
// strips one decimal digit with a reciprocal multiply, before the serializer
// registers its command write. The output serializer emits one write per
// cycle while the receiver takes them; a request makes 3 writes in hex mode
// or digit count + 1 writes in decimal mode (at most 6). The pipeline accepts a
// request in every cycle while it has room, so requests queue up behind a
// busy serializer.
// When the receiver stalls, the pending write holds and the pipeline stages
// fill up; o_ready drops only when every stage holds a request.
// Reset is synchronous; it empties the pipeline and the output register.
module char_lcd_number_formatter_unit #(
    parameter int MAX_DIGITS = clnf_pkg::MAX_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [15:0] i_value,
    input  logic [2:0]  i_digit_count,
    input  logic        i_blank_zeros,
    input  logic [1:0]  i_row,
    input  logic [4:0]  i_column,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_data,
    output logic [7:0]  o_bus_byte,
    output logic        o_last
);

    // Stage 0 registers the request, stages 1..MAX_DIGITS each add one digit.
    localparam int NS = MAX_DIGITS + 1;
    localparam int DW = (MAX_DIGITS > 2) ? $clog2(MAX_DIGITS) : 1;

    typedef struct packed {
        logic                        mode;
        logic                        blank;
        logic [2:0]                  count;
        logic [7:0]                  addr;
        logic [7:0]                  hex;
        logic [15:0]                 rem;
        logic [MAX_DIGITS-1:0][3:0]  dig;
    } t_stage;

    t_stage          r_st [NS];
    t_stage          n_st [NS];
    logic [NS-1:0]   r_v;
    logic [NS-1:0]   w_adv;
    logic            w_take;
    logic            w_out_load;

    // Output serializer state.
    t_stage          r_cur;
    logic            r_busy;
    logic [2:0]      r_idx;
    logic            r_lead;
    logic            n_busy;
    logic [2:0]      n_idx;
    logic            n_lead;

    logic            r_out_valid;
    logic            r_out_is_data;
    logic [7:0]      r_out_byte;
    logic            r_out_last;
    logic            n_out_valid;
    logic            n_out_is_data;
    logic [7:0]      n_out_byte;
    logic            n_out_last;

    // ------------------------------------------------------------------
    // Input stage: address and clamped digit count.
    // ------------------------------------------------------------------
    always_comb begin
        logic [2:0] cnt;
        logic [15:0] rem;
        logic [32:0] prod;
        logic [13:0] quo;
        logic [15:0] back;

        cnt = i_digit_count;
        if (cnt < 3'd2) begin
            cnt = 3'd2;
        end else if (cnt > 3'(MAX_DIGITS)) begin
            cnt = 3'(MAX_DIGITS);
        end
        n_st[0].mode  = i_mode;
        n_st[0].blank = i_blank_zeros;
        n_st[0].count = cnt;
        n_st[0].addr  = clnf_pkg::ROW_BASE[i_row] + {3'd0, i_column};
        n_st[0].hex   = i_value[7:0];
        n_st[0].rem   = i_value;
        n_st[0].dig   = '0;

        // Each digit stage divides the remaining value by ten.
        for (int j = 1; j < NS; j++) begin
            rem  = r_st[j-1].rem;
            prod = {17'd0, rem} * {16'd0, clnf_pkg::DIV10_MULT};
            quo  = prod[clnf_pkg::DIV10_SHIFT+13:clnf_pkg::DIV10_SHIFT];
            back = {quo, 2'b00} + {2'b00, quo};
            back = {back[14:0], 1'b0};
            n_st[j]          = r_st[j-1];
            n_st[j].rem      = {2'd0, quo};
            n_st[j].dig[j-1] = 4'(rem - back);
        end
    end

    // A stage moves on when it is empty or its successor moves on.
    always_comb begin
        w_adv[NS-1] = !r_v[NS-1] || w_take;
        for (int j = NS - 2; j >= 0; j--) begin
            w_adv[j] = !r_v[j] || w_adv[j+1];
        end
    end

    assign o_ready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int j = 1; j < NS; j++) begin
                if (w_adv[j]) begin
                    r_v[j] <= r_v[j-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0] && i_valid) begin
            r_st[0] <= n_st[0];
        end
        for (int j = 1; j < NS; j++) begin
            if (w_adv[j] && r_v[j-1]) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Serializer: one bus write per cycle into the output register, held while the receiver stalls.
    // ------------------------------------------------------------------
    assign w_out_load = !r_out_valid || i_ready;

    always_comb begin
        logic [2:0] pos;
        logic [3:0] dig;

        pos = r_cur.count - r_idx;
        dig = r_cur.dig[pos[DW-1:0]];

        w_take        = 1'b0;
        n_busy        = r_busy;
        n_idx         = r_idx;
        n_lead        = r_lead;
        n_out_valid   = 1'b0;
        n_out_is_data = 1'b1;
        n_out_byte    = clnf_pkg::CHR_SPACE;
        n_out_last    = 1'b0;

        if (r_busy) begin
            n_out_valid = 1'b1;
            n_idx       = r_idx + 3'd1;
            if (r_cur.mode) begin
                n_out_byte = (r_idx == 3'd1) ? clnf_pkg::hex_char(r_cur.hex[7:4])
                                             : clnf_pkg::hex_char(r_cur.hex[3:0]);
                n_out_last = (r_idx == 3'd2);
            end else begin
                // Leading zeros are blanked until the first nonzero digit;
                // the units digit always prints.
                if (r_lead && dig == 4'd0 && pos != 3'd0) begin
                    n_out_byte = clnf_pkg::CHR_SPACE;
                end else begin
                    n_lead     = 1'b0;
                    n_out_byte = clnf_pkg::CHR_ZERO + {4'd0, dig};
                end
                n_out_last = (r_idx == r_cur.count);
            end
            if (n_out_last) begin
                n_busy = 1'b0;
            end
        end else if (r_v[NS-1]) begin
            w_take        = w_out_load;
            n_busy        = 1'b1;
            n_idx         = 3'd1;
            n_lead        = r_st[NS-1].blank;
            n_out_valid   = 1'b1;
            n_out_is_data = 1'b0;
            n_out_byte    = r_st[NS-1].addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_idx         <= n_idx;
            r_lead        <= n_lead;
            r_out_is_data <= n_out_is_data;
            r_out_byte    <= n_out_byte;
            r_out_last    <= n_out_last;
        end
        if (w_take) begin
            r_cur <= r_st[NS-1];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_is_data  = r_out_is_data;
    assign o_bus_byte = r_out_byte;
    assign o_last     = r_out_last;

endmodule

### src/clnf_checker.sv
module clnf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_is_data,
    input logic [7:0] o_bus_byte,
    input logic       o_last
);

    // A stalled write holds its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_bus_byte)
                                && $stable(o_is_data) && $stable(o_last))
        else $error("stalled write changed");

    // Characters of one request follow each other without a gap.
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid && o_is_data)
        else $error("request writes broken up");

    // The write after a final one is the next request's address command.
    a_cmd_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_last |=> !o_valid || !o_is_data)
        else $error("request did not start with a command");

    // Data writes are a space, a decimal digit or an uppercase hex letter.
    a_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_data |-> o_bus_byte == 8'h20
            || (o_bus_byte >= 8'h30 && o_bus_byte <= 8'h39)
            || (o_bus_byte >= 8'h41 && o_bus_byte <= 8'h46))
        else $error("unexpected character");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind char_lcd_number_formatter_unit clnf_checker u_clnf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_is_data  (o_is_data),
    .o_bus_byte (o_bus_byte),
    .o_last     (o_last)
);

### bench/lcd_bus_checker.sv
`timescale 1ns / 1ps

package clnf_tb_pkg;

    typedef enum logic {FMT_DECIMAL = 1'b0, FMT_HEX = 1'b1} t_fmt_mode;
    typedef enum logic {WR_COMMAND = 1'b0, WR_DATA = 1'b1} t_wr_kind;

endpackage

module lcd_bus_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_mode,
    input  logic [15:0] i_value,
    input  logic [2:0]  i_digit_count,
    input  logic        i_blank_zeros,
    input  logic [1:0]  i_row,
    input  logic [4:0]  i_column,
    input  logic        i_wr_valid,
    input  logic        i_wr_ready,
    input  logic        i_is_data,
    input  logic [7:0]  i_bus_byte,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_writes_due
);

    localparam int         DIGITS_MAX   = 5;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_LETTER = 8'h37;
    localparam logic [7:0] ASCII_BLANK  = 8'h20;

    typedef struct packed {
        clnf_tb_pkg::t_wr_kind kind;
        logic [7:0]            bus_byte;
        logic                  last;
    } t_lcd_write;

    t_lcd_write writes_due[$];
    int         fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic t_lcd_write bus_write(input clnf_tb_pkg::t_wr_kind kind,
                                             input logic [7:0] bus_byte, input logic last);
        t_lcd_write wr;
        wr.kind     = kind;
        wr.bus_byte = bus_byte;
        wr.last     = last;
        return wr;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        return (nib > 4'd9) ? ASCII_LETTER + {4'd0, nib} : ASCII_ZERO + {4'd0, nib};
    endfunction

    // Queues every bus write that one request produces.
    function automatic void expand_request(input clnf_tb_pkg::t_fmt_mode mode,
                                           input logic [15:0] value,
                                           input logic [2:0] count_field, input logic blank,
                                           input logic [1:0] row, input logic [4:0] column);
        logic [7:0] base;
        logic [3:0] digit [DIGITS_MAX];
        logic [7:0] ch;
        int         count;
        int         rest;
        int         i;
        logic       leading;
        case (row)
            2'd0: base = 8'h80;
            2'd1: base = 8'hC0;
            2'd2: base = 8'h94;
            default: base = 8'hD4;
        endcase
        writes_due.push_back(bus_write(clnf_tb_pkg::WR_COMMAND, base + {3'd0, column}, 1'b0));
        if (mode == clnf_tb_pkg::FMT_HEX) begin
            writes_due.push_back(bus_write(clnf_tb_pkg::WR_DATA, hex_ascii(value[7:4]), 1'b0));
            writes_due.push_back(bus_write(clnf_tb_pkg::WR_DATA, hex_ascii(value[3:0]), 1'b1));
            return;
        end
        count = int'(count_field);
        if (count < 2) count = 2;
        if (count > DIGITS_MAX) count = DIGITS_MAX;
        rest = int'(value);
        for (i = 0; i < DIGITS_MAX; i++) begin
            digit[i] = 4'(rest % 10);
            rest = rest / 10;
        end
        leading = blank;
        for (i = count - 1; i >= 0; i--) begin
            if (leading && digit[i] == 4'd0 && i > 0) begin
                ch = ASCII_BLANK;
            end else begin
                leading = 1'b0;
                ch = ASCII_ZERO + {4'd0, digit[i]};
            end
            writes_due.push_back(bus_write(clnf_tb_pkg::WR_DATA, ch, i == 0));
        end
    endfunction

    always @(posedge i_clk) begin
        t_lcd_write want;
        if (!i_rst_n) begin
            writes_due.delete();
            o_writes_due <= 0;
        end else begin
            if ($isunknown(i_wr_valid) || $isunknown(i_req_ready)) begin
                $display("%0t: handshake signal unknown: expected 0/1, actual valid %b ready %b",
                         $time, i_wr_valid, i_req_ready);
                fail_total++;
            end
            if (i_wr_valid && i_wr_ready) begin
                if (writes_due.size() == 0) begin
                    $display("%0t: unexpected write: expected none, actual data %b byte %h last %b",
                             $time, i_is_data, i_bus_byte, i_last);
                    fail_total++;
                end else begin
                    want = writes_due.pop_front();
                    if (i_is_data !== want.kind) begin
                        $display("%0t: is_data mismatch: expected %b, actual %b",
                                 $time, want.kind, i_is_data);
                        fail_total++;
                    end
                    if (i_bus_byte !== want.bus_byte) begin
                        $display("%0t: bus_byte mismatch: expected %h, actual %h",
                                 $time, want.bus_byte, i_bus_byte);
                        fail_total++;
                    end
                    if (i_last !== want.last) begin
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, want.last, i_last);
                        fail_total++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                expand_request(clnf_tb_pkg::t_fmt_mode'(i_mode), i_value, i_digit_count,
                               i_blank_zeros, i_row, i_column);
            end
            o_writes_due <= writes_due.size();
        end
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the character LCD number formatter. The checker beside the
// block watches both channels, predicts every bus write and reports mismatches; this
// module only generates traffic and decides pass or fail from the checker's count.
module tb_top;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_REQUESTS = 270;
    localparam int CALM_TAIL       = 60;
    localparam int BURST_REQUESTS  = 40;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int FLUSH_CYCLES    = 40;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        req_valid       = 1'b0;
    logic        req_ready;
    logic        req_mode        = 1'b0;
    logic [15:0] req_value       = 16'd0;
    logic [2:0]  req_digit_count = 3'd2;
    logic        req_blank       = 1'b0;
    logic [1:0]  req_row         = 2'd0;
    logic [4:0]  req_column      = 5'd0;
    logic        wr_valid;
    logic        wr_ready        = 1'b0;
    logic        wr_is_data;
    logic [7:0]  wr_bus_byte;
    logic        wr_last;

    // A request transaction seen at a rising edge is visible here at the next falling edge,
    // which is where the sender decides what to drive next.
    logic        req_taken       = 1'b0;
    // The receiver stalls in random bursts only while this is set.
    logic        stall_enable    = 1'b0;
    // Long hold-offs asked by the sequence and carried out by the receiver process.
    int          holds_asked     = 0;
    int          holds_served    = 0;
    int          fail_count;
    int          writes_due;

    char_lcd_number_formatter_unit u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (req_valid),
        .o_ready       (req_ready),
        .i_mode        (req_mode),
        .i_value       (req_value),
        .i_digit_count (req_digit_count),
        .i_blank_zeros (req_blank),
        .i_row         (req_row),
        .i_column      (req_column),
        .o_valid       (wr_valid),
        .i_ready       (wr_ready),
        .o_is_data     (wr_is_data),
        .o_bus_byte    (wr_bus_byte),
        .o_last        (wr_last)
    );

    lcd_bus_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_mode        (req_mode),
        .i_value       (req_value),
        .i_digit_count (req_digit_count),
        .i_blank_zeros (req_blank),
        .i_row         (req_row),
        .i_column      (req_column),
        .i_wr_valid    (wr_valid),
        .i_wr_ready    (wr_ready),
        .i_is_data     (wr_is_data),
        .i_bus_byte    (wr_bus_byte),
        .i_last        (wr_last),
        .o_fail_count  (fail_count),
        .o_writes_due  (writes_due)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        req_taken <= req_valid && req_ready;
    end

    // Watchdog: a hung handshake or a lost write ends the run here.
    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Receiver side. It is ready by default, stalls in short random bursts while enabled,
    // and serves each requested long hold-off by counting cycles on its own.
    initial begin
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            if (holds_served != holds_asked) begin
                wr_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                holds_served++;
            end else if (stall_enable && $urandom_range(0, 5) == 0) begin
                wr_ready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end else begin
                wr_ready = 1'b1;
                @(negedge clk);
            end
        end
    end

    // Offers one request at a falling edge and returns at the falling edge after its
    // transaction. The valid stays high, so a following call keeps the channel busy.
    task automatic send_request(input clnf_tb_pkg::t_fmt_mode mode, input logic [15:0] value,
                                input logic [2:0] count, input logic blank,
                                input logic [1:0] row, input logic [4:0] column);
        req_mode        = mode;
        req_value       = value;
        req_digit_count = count;
        req_blank       = blank;
        req_row         = row;
        req_column      = column;
        req_valid       = 1'b1;
        @(negedge clk);
        while (!req_taken) @(negedge clk);
    endtask

    // Random request. Values lean toward small numbers and round thousands so that
    // blanking and embedded zeros come up often; out-of-range digit counts and
    // columns past the row end appear now and then.
    task automatic send_random_request();
        logic [15:0]             value;
        logic [2:0]              count;
        logic [4:0]              column;
        clnf_tb_pkg::t_fmt_mode  mode;
        case ($urandom_range(0, 4))
            0: value = 16'($urandom_range(0, 9));
            1: value = 16'($urandom_range(0, 999));
            2: value = 16'($urandom_range(0, 65) * 1000);
            default: value = 16'($urandom);
        endcase
        count  = 3'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
                                                : $urandom_range(2, 5));
        column = 5'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(0, 19));
        mode   = ($urandom_range(0, 3) == 0) ? clnf_tb_pkg::FMT_HEX : clnf_tb_pkg::FMT_DECIMAL;
        send_request(mode, value, count, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                     column);
    endtask

    // Pauses the sender until every predicted write has been seen on the bus.
    task automatic wait_drained();
        req_valid = 1'b0;
        while (writes_due != 0) @(negedge clk);
    endtask

    initial begin
        int  n;
        logic calm;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part with the receiver always ready. Decimal cases cover all-zero
        // values with and without blanking, the largest value at widths 2, 3 and 5, zeros
        // in the middle of a number, values too wide for the digit count, and digit
        // counts below and above the legal range. Hex cases cover both byte extremes,
        // letters and digits in each nibble, and ignored count and blank fields.
        // Rows and columns include every row base and columns past 19.
        send_request(clnf_tb_pkg::FMT_DECIMAL, 16'd0,     3'd5, 1'b1, 2'd0, 5'd0);
        send_request(clnf_tb_pkg::FMT_DECIMAL, 16'd0,     3'd5, 1'b0, 2'd1, 5'd19);
        send_request(clnf_tb_pkg::FMT_DECIMAL, 16'd65535, 3'd5, 1'b1, 2'd2, 5'd5);
        send_request(clnf_tb_pkg::FMT_DECIMAL, 16'd65535, 3'd2, 1'b0, 2'd3, 5'd31);
        send_request(clnf_tb_pkg::FMT_DECIMAL, 16'd65535, 3'd3, 1'b1, 2'd2, 5'd31);
        send_request(clnf_tb_pkg::FMT_DECIMAL, 16'd10005, 3'd5, 1'b1, 2'd0, 5'd10);
        send_request(clnf_tb_pkg::FMT_DECIMAL, 16'd7,     3'd3, 1'b1, 2'd1, 5'd1);
        send_request(clnf_tb_pkg::FMT_DECIMAL, 16'd7,     3'd0, 1'b1, 2'd2, 5'd2);
        send_request(clnf_tb_pkg::FMT_DECIMAL, 16'd1234,  3'd1, 1'b0, 2'd3, 5'd3);
        send_request(clnf_tb_pkg::FMT_DECIMAL, 16'd1234,  3'd6, 1'b1, 2'd0, 5'd4);
        send_request(clnf_tb_pkg::FMT_DECIMAL, 16'd54321, 3'd7, 1'b0, 2'd1, 5'd16);
        send_request(clnf_tb_pkg::FMT_DECIMAL, 16'd100,   3'd4, 1'b1, 2'd2, 5'd8);
        send_request(clnf_tb_pkg::FMT_DECIMAL, 16'd9,     3'd2, 1'b0, 2'd3, 5'd0);
        send_request(clnf_tb_pkg::FMT_DECIMAL, 16'd40000, 3'd4, 1'b1, 2'd0, 5'd15);
        send_request(clnf_tb_pkg::FMT_DECIMAL, 16'd99,    3'd2, 1'b1, 2'd1, 5'd20);
        send_request(clnf_tb_pkg::FMT_HEX,     16'h0000,  3'd2, 1'b0, 2'd0, 5'd0);
        send_request(clnf_tb_pkg::FMT_HEX,     16'hFFFF,  3'd5, 1'b1, 2'd3, 5'd19);
        send_request(clnf_tb_pkg::FMT_HEX,     16'h12A5,  3'd7, 1'b1, 2'd1, 5'd7);
        send_request(clnf_tb_pkg::FMT_HEX,     16'hBC5A,  3'd0, 1'b0, 2'd2, 5'd20);
        send_request(clnf_tb_pkg::FMT_HEX,     16'h0009,  3'd3, 1'b1, 2'd3, 5'd31);
        send_request(clnf_tb_pkg::FMT_HEX,     16'h00F0,  3'd1, 1'b0, 2'd0, 5'd12);

        // Let everything out before the pressure test starts.
        wait_drained();

        // Long receiver hold-off while the sender keeps offering back to back, so the
        // pipeline fills and the input side has to stall.
        holds_asked++;
        for (n = 0; n < BURST_REQUESTS; n++) begin
            send_random_request();
        end
        wait_drained();

        // Main random traffic. Both sides idle in bursts for most of each 80-request
        // window and run flat out for the rest; the final stretch has no idling at all.
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            calm = (n >= RANDOM_REQUESTS - CALM_TAIL);
            stall_enable = !calm && (n % 80) < 60;
            if (stall_enable && $urandom_range(0, 5) == 0) begin
                req_valid = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            send_random_request();
        end

        // Drain, then give the pipeline time to show any stray write.
        wait_drained();
        repeat (FLUSH_CYCLES) @(negedge clk);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
